@@ rtl/core/base64_stream_encoder_defines.svh @@
// Assertion macros used by the checker of the base64 stream encoder.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define B64_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define B64_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/b64enc_pkg.sv @@
// Types, constants and the character mapping of the base64 stream encoder.
package b64enc_pkg;

  localparam logic [7:0] PAD_CHAR  = 8'h3D;
  localparam logic [1:0] LAST_SLOT = 2'd3;

  // One encoded group of four characters, first character in slot 0.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            last;
  } grp_t;

  // Maps a 6-bit code to its ASCII character; only codes 62 and 63 depend
  // on the alphabet, and unused alphabet numbers select the standard one.
  function automatic logic [7:0] map_code(input logic [5:0] code,
                                          input logic [3:0] variant);
    logic [15:0] tail;
    logic [7:0]  ch;
    case (variant)
      4'd1:    tail = {8'h2F, 8'h2B};
      4'd2:    tail = {8'h5F, 8'h2D};
      4'd3:    tail = {8'h2D, 8'h5F};
      4'd4:    tail = {8'h21, 8'h2D};
      4'd5:    tail = {8'h2D, 8'h21};
      4'd6:    tail = {8'h5F, 8'h2E};
      4'd7:    tail = {8'h2E, 8'h5F};
      4'd8:    tail = {8'h2E, 8'h2D};
      4'd9:    tail = {8'h2D, 8'h2E};
      4'd10:   tail = {8'h3A, 8'h5F};
      4'd11:   tail = {8'h5F, 8'h3A};
      default: tail = {8'h2B, 8'h2F};
    endcase
    if (code < 6'd26) begin
      ch = 8'h41 + {2'b00, code};
    end else if (code < 6'd52) begin
      ch = 8'h61 + {2'b00, code} - 8'd26;
    end else if (code < 6'd62) begin
      ch = 8'h30 + {2'b00, code} - 8'd52;
    end else begin
      ch = code[0] ? tail[7:0] : tail[15:8];
    end
    return ch;
  endfunction

endpackage

@@ rtl/core/base64_stream_encoder.sv @@
// Top level of the base64 stream encoder: byte input, one character per word out.
// Path: the byte that completes or ends a group is registered into grp, then into the serialiser.
// Flow: bytes are taken one a cycle until one finishes a group; the input then waits
// until that group moves to the serialiser. Each group gives four characters, one a
// cycle while out_ready is high, through the single-character output port.
// Reset (rst, synchronous, active high) empties the held bytes and both group stages and
// sets the alphabet to the standard one.
module base64_stream_encoder
  import b64enc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] alphabet_variant,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_char
);

  // The alphabet register. The user must send writes only while the block is idle; the
  // block does not enforce this. cfg_ready is tied high, so the port can always take a word.
  logic [3:0] variant;

  // Bytes waiting for a complete group, newest in the low byte.
  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  logic [15:0] held_bytes_next;
  logic [1:0]  held_count_next;

  // A finished group waits in grp until the serialiser is free, so a new
  // byte can be taken while the previous group is still going out.
  grp_t grp;
  logic grp_valid;
  grp_t grp_next;
  logic produce;

  // The serialiser: the group on show and the slot being presented.
  grp_t       ser;
  logic       ser_valid;
  logic [1:0] ser_idx;
  logic       ser_free;

  logic in_fire;
  logic out_fire;

  logic [1:0]      cnt;
  logic [3:0][5:0] code;
  logic [3:0]      pad;

  assign cfg_ready = 1'b1;
  assign in_ready  = !grp_valid;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = ser_valid;
  assign out_fire  = ser_valid && out_ready;
  assign out_char  = ser.chars[ser_idx];
  assign last_char = ser.last && (ser_idx == LAST_SLOT);

  // The serialiser takes the waiting group when it is empty or once its last character leaves.
  assign ser_free = !ser_valid || (out_fire && (ser_idx == LAST_SLOT));

  // Split the held bytes and the incoming byte into four 6-bit codes. A
  // count of three cannot occur and is treated as an empty group.
  always_comb begin
    cnt = (held_count == 2'd3) ? 2'd0 : held_count;
    case (cnt)
      2'd2: begin
        code[0] = held_bytes[15:10];
        code[1] = {held_bytes[9:8], held_bytes[7:4]};
        code[2] = {held_bytes[3:0], data_byte[7:6]};
        code[3] = data_byte[5:0];
        pad     = 4'b0000;
      end
      2'd1: begin
        code[0] = held_bytes[7:2];
        code[1] = {held_bytes[1:0], data_byte[7:4]};
        code[2] = {data_byte[3:0], 2'b00};
        code[3] = 6'd0;
        pad     = 4'b1000;
      end
      default: begin
        code[0] = data_byte[7:2];
        code[1] = {data_byte[1:0], 4'b0000};
        code[2] = 6'd0;
        code[3] = 6'd0;
        pad     = 4'b1100;
      end
    endcase

    // A full group, or the end of the message, gives four characters.
    produce = (cnt == 2'd2) || last_byte;

    for (int i = 0; i < 4; i++) begin
      grp_next.chars[i] = pad[i] ? PAD_CHAR : map_code(code[i], variant);
    end
    grp_next.last = last_byte;

    if (produce) begin
      held_bytes_next = 16'd0;
      held_count_next = 2'd0;
    end else begin
      held_bytes_next = {held_bytes[7:0], data_byte};
      held_count_next = cnt + 2'd1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      variant    <= 4'd0;
      held_bytes <= 16'd0;
      held_count <= 2'd0;
      grp_valid  <= 1'b0;
      ser_valid  <= 1'b0;
      ser_idx    <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        variant <= alphabet_variant;
      end

      if (ser_free && grp_valid) begin
        ser_valid <= 1'b1;
        ser_idx   <= 2'd0;
        grp_valid <= 1'b0;
      end else if (out_fire) begin
        if (ser_idx == LAST_SLOT) begin
          ser_valid <= 1'b0;
        end else begin
          ser_idx <= ser_idx + 2'd1;
        end
      end

      // in_ready is low while a group waits, so this never meets the
      // hand-over above.
      if (in_fire) begin
        held_bytes <= held_bytes_next;
        held_count <= held_count_next;
        if (produce) begin
          grp_valid <= 1'b1;
        end
      end
    end
  end

  // Group payloads need no reset.
  always_ff @(posedge clk) begin
    if (in_fire && produce) begin
      grp <= grp_next;
    end
    if (ser_free && grp_valid) begin
      ser <= grp;
    end
  end

endmodule

@@ rtl/core/b64enc_checker.sv @@
// Port-level checker for the base64 stream encoder and its bind statement.
`include "base64_stream_encoder_defines.svh"

module b64enc_checker
  import b64enc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       last_char
);

  // A stalled output word keeps its character and end mark.
  `B64_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last_char), "output word changed while stalled")

  // Reset empties the output side.
  `B64_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid, "output valid after reset")

  // A pad that is not final is followed at once by the closing pad.
  `B64_ASSERT(a_double_pad, clk, rst, out_valid && out_ready && out_char == PAD_CHAR && !last_char |=> out_valid && out_char == PAD_CHAR && last_char, "first pad not followed by final pad")

  // Input is only held back while a finished group waits for the serialiser.
  `B64_ASSERT(a_backpressure, clk, rst, !in_ready |=> out_valid, "input stalled with no output pending")

endmodule

bind base64_stream_encoder b64enc_checker u_b64enc_checker (.*);
